/* hdl/assert_macros.svh */
// Assertion helpers: clocked, with or without a reset qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("check failed");

`define CHK_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) else $error("check failed");

`endif

/* hdl/spmm_pkg.sv */
package spmm_pkg;

    localparam int ACC_W = 48;
    localparam int VAL_W = 32;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_A       = 2'd1;
    localparam logic [1:0] OP_END     = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic CFG_INNER_SIZE = 1'b0;
    localparam logic CFG_OUT_COLS   = 1'b1;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [15:0]              row;
        logic [7:0]               col;
        logic signed [VAL_W-1:0]  value;
    } spmm_in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [15:0]              out_row;
        logic [5:0]               out_col;
        logic signed [VAL_W-1:0]  out_value;
        logic                     last;
    } spmm_out_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 48'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -48'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = VAL_W'(v);
        end
        return r;
    endfunction

endpackage

/* hdl/spmm_mac.sv */
module spmm_mac import spmm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     load,
    input  logic signed [VAL_W-1:0]  a,
    input  logic signed [VAL_W-1:0]  b,
    input  logic signed [ACC_W-1:0]  acc_in,
    output logic signed [ACC_W-1:0]  acc_out
);

    localparam logic signed [63:0] P_MAX = 64'sh00007FFFFFFFFFFF;
    localparam logic signed [63:0] P_MIN = -64'sh0000800000000000;
    localparam logic signed [48:0] S_MAX = 49'sh07FFFFFFFFFFF;
    localparam logic signed [48:0] S_MIN = -49'sh0800000000000;

    logic signed [63:0]      prod_reg;
    logic signed [63:0]      shifted;
    logic signed [ACC_W-1:0] prod48;
    logic signed [48:0]      sum49;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= 64'(a) * 64'(b);
        end
    end

    always_comb
    begin
        shifted = prod_reg >>> FRAC_BITS;
        if (shifted > P_MAX)
        begin
            prod48 = ACC_W'(P_MAX);
        end
        else if (shifted < P_MIN)
        begin
            prod48 = ACC_W'(P_MIN);
        end
        else
        begin
            prod48 = ACC_W'(shifted);
        end
        sum49 = 49'(acc_in) + 49'(prod48);
        if (sum49 > S_MAX)
        begin
            acc_out = ACC_W'(S_MAX);
        end
        else if (sum49 < S_MIN)
        begin
            acc_out = ACC_W'(S_MIN);
        end
        else
        begin
            acc_out = ACC_W'(sum49);
        end
    end

endmodule

/* hdl/sparse_row_wise_matmul.sv */
// Row-wise sparse matrix product engine (C = A * B on coordinate entries).
// Request channel: drive item and pulse start while busy is low; the request
// is taken at that edge and busy stays high until all its work is done.
// Opcodes: load a B entry, apply an A entry, end of A, restart.
// Results appear on result for one cycle each with result_valid high; the
// receiver must take them, there is no back-pressure. The final result of
// a request carries last.
// The first A entry also runs a prefix pass that turns the B row counts
// into row offsets; each valid A entry then multiplies by every B term of
// the selected row, and a row flush scans and clears the accumulators.
// The work runs through the single multiply-accumulate unit and the
// accumulator memory, which has one read port and one write port.
// Reset and restart run a clearing pass over the row offset and
// accumulator memories, busy high; config writes (cfg_we, cfg_index,
// cfg_data) are taken at any time.
module sparse_row_wise_matmul import spmm_pkg::*; #(
    parameter int MAX_TERMS    = 1024,
    parameter int MAX_INNER    = 256,
    parameter int MAX_OUT_COLS = 64,
    parameter int FRAC_BITS    = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  spmm_in_t  item,
    output logic      busy,
    output logic      result_valid,
    output spmm_out_t result,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [8:0] cfg_data
);

`include "assert_macros.svh"

    localparam int RS_DEPTH = MAX_INNER + 1;
    localparam int RSA_W    = $clog2(RS_DEPTH);
    localparam int TT_W     = $clog2(MAX_TERMS + 1);
    localparam int TA_W     = $clog2(MAX_TERMS);
    localparam int AW       = $clog2(MAX_OUT_COLS);
    localparam int CLR_N    = (RS_DEPTH > MAX_OUT_COLS) ? RS_DEPTH : MAX_OUT_COLS;
    localparam int CLR_W    = $clog2(CLR_N);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLEAR  = 5'd1;
    localparam logic [4:0] S_DECODE = 5'd2;
    localparam logic [4:0] S_L_RD   = 5'd3;
    localparam logic [4:0] S_L_WR   = 5'd4;
    localparam logic [4:0] S_PFX_RD = 5'd5;
    localparam logic [4:0] S_PFX_WR = 5'd6;
    localparam logic [4:0] S_A_CHK  = 5'd7;
    localparam logic [4:0] S_A_LO   = 5'd8;
    localparam logic [4:0] S_A_HI   = 5'd9;
    localparam logic [4:0] S_A_HI2  = 5'd10;
    localparam logic [4:0] S_T_RD   = 5'd11;
    localparam logic [4:0] S_T_MUL  = 5'd12;
    localparam logic [4:0] S_T_ACC  = 5'd13;
    localparam logic [4:0] S_FL_RD  = 5'd14;
    localparam logic [4:0] S_FL_CHK = 5'd15;
    localparam logic [4:0] S_FL_END = 5'd16;

    logic [4:0]       state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic [RSA_W-1:0] rs_ptr_reg, rs_ptr_next;
    logic [TT_W-1:0]  term_total_reg, term_total_next;
    logic [RSA_W-1:0] prev_row_reg, prev_row_next;
    logic [15:0]      cur_row_reg, cur_row_next;
    logic             row_open_reg, row_open_next;
    logic             a_phase_reg, a_phase_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             res_valid_reg, res_valid_next;
    logic [AW-1:0]    fl_j_reg, fl_j_next;
    logic             then_acc_reg, then_acc_next;
    logic [TT_W-1:0]  tptr_reg, tptr_next;
    logic [8:0]       inner_size_reg;
    logic [6:0]       out_cols_reg;

    spmm_in_t                item_reg, item_next;
    spmm_out_t               res_reg, res_next;
    logic [AW-1:0]           pend_col_reg, pend_col_next;
    logic signed [VAL_W-1:0] pend_val_reg, pend_val_next;
    logic [AW-1:0]           acc_col_reg, acc_col_next;
    logic [TT_W-1:0]         hi_reg, hi_next;
    logic [TT_W-1:0]         run_reg, run_next;

    logic [TT_W-1:0]         rs_mem [RS_DEPTH];
    logic [TT_W-1:0]         rs_rd_reg;
    logic                    rs_we;
    logic [RSA_W-1:0]        rs_waddr;
    logic [TT_W-1:0]         rs_wdata;

    logic signed [ACC_W-1:0] acc_mem [MAX_OUT_COLS];
    logic signed [ACC_W-1:0] acc_rd_reg;
    logic                    acc_we;
    logic [AW-1:0]           acc_waddr;
    logic [AW-1:0]           acc_raddr;
    logic signed [ACC_W-1:0] acc_wdata;

    logic [AW-1:0]           tcol_mem [MAX_TERMS];
    logic signed [VAL_W-1:0] tval_mem [MAX_TERMS];
    logic [AW-1:0]           tcol_rd_reg;
    logic signed [VAL_W-1:0] tval_rd_reg;
    logic                    term_we;

    logic                    mac_load;
    logic signed [ACC_W-1:0] mac_out;

    logic [16:0]             inner17;
    logic [6:0]              cols7;
    logic [TT_W-1:0]         pfx_sum;

    assign inner17 = (17'(inner_size_reg) < 17'(MAX_INNER)) ? 17'(inner_size_reg)
                                                             : 17'(MAX_INNER);
    assign cols7   = (out_cols_reg < 7'(MAX_OUT_COLS)) ? out_cols_reg : 7'(MAX_OUT_COLS);
    assign pfx_sum = run_reg + rs_rd_reg;
    assign acc_raddr = (state_reg == S_T_MUL) ? tcol_rd_reg : fl_j_reg;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    spmm_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk     (clk),
        .load    (mac_load),
        .a       (item_reg.value),
        .b       (tval_rd_reg),
        .acc_in  (acc_rd_reg),
        .acc_out (mac_out)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        rs_ptr_next     = rs_ptr_reg;
        term_total_next = term_total_reg;
        prev_row_next   = prev_row_reg;
        cur_row_next    = cur_row_reg;
        row_open_next   = row_open_reg;
        a_phase_next    = a_phase_reg;
        pend_valid_next = pend_valid_reg;
        res_valid_next  = 1'b0;
        fl_j_next       = fl_j_reg;
        then_acc_next   = then_acc_reg;
        tptr_next       = tptr_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        pend_col_next   = pend_col_reg;
        pend_val_next   = pend_val_reg;
        acc_col_next    = acc_col_reg;
        hi_next         = hi_reg;
        run_next        = run_reg;
        rs_we           = 1'b0;
        rs_waddr        = rs_ptr_reg;
        rs_wdata        = '0;
        acc_we          = 1'b0;
        acc_waddr       = fl_j_reg;
        acc_wdata       = '0;
        term_we         = 1'b0;
        mac_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_DECODE;
                end
            end
            S_CLEAR:
            begin
                rs_we     = (int'(clr_reg) < RS_DEPTH);
                rs_waddr  = clr_reg[RSA_W-1:0];
                acc_we    = (int'(clr_reg) < MAX_OUT_COLS);
                acc_waddr = clr_reg[AW-1:0];
                if (int'(clr_reg) == CLR_N - 1)
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + CLR_W'(1);
                end
            end
            S_DECODE:
            begin
                unique case (item_reg.opcode)
                    OP_LOAD:
                    begin
                        res_next = '{ST_OK, item_reg.row, 6'd0, '0, 1'b1};
                        if ((17'(item_reg.row) >= inner17) || (item_reg.col >= 8'(cols7)))
                        begin
                            res_next.status = ST_RANGE;
                            res_valid_next  = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else if (a_phase_reg || ((term_total_reg != '0) &&
                                 (17'(item_reg.row) < 17'(prev_row_reg))))
                        begin
                            res_next.status = ST_ORDER;
                            res_valid_next  = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else if (term_total_reg == TT_W'(MAX_TERMS))
                        begin
                            res_next.status = ST_FULL;
                            res_valid_next  = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            term_we         = 1'b1;
                            term_total_next = term_total_reg + TT_W'(1);
                            prev_row_next   = RSA_W'(item_reg.row);
                            rs_ptr_next     = RSA_W'(item_reg.row) + RSA_W'(1);
                            state_next      = S_L_RD;
                        end
                    end
                    OP_A:
                    begin
                        if (!a_phase_reg)
                        begin
                            rs_ptr_next = RSA_W'(1);
                            run_next    = '0;
                            state_next  = S_PFX_RD;
                        end
                        else
                        begin
                            state_next = S_A_CHK;
                        end
                    end
                    OP_END:
                    begin
                        if (row_open_reg)
                        begin
                            fl_j_next     = '0;
                            then_acc_next = 1'b0;
                            state_next    = S_FL_RD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    OP_RESTART:
                    begin
                        term_total_next = '0;
                        prev_row_next   = '0;
                        cur_row_next    = '0;
                        row_open_next   = 1'b0;
                        a_phase_next    = 1'b0;
                        pend_valid_next = 1'b0;
                        clr_next        = '0;
                        state_next      = S_CLEAR;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_L_RD:
            begin
                state_next = S_L_WR;
            end
            S_L_WR:
            begin
                rs_we      = 1'b1;
                rs_wdata   = rs_rd_reg + TT_W'(1);
                state_next = S_IDLE;
            end
            S_PFX_RD:
            begin
                state_next = S_PFX_WR;
            end
            S_PFX_WR:
            begin
                rs_we    = 1'b1;
                rs_wdata = pfx_sum;
                run_next = pfx_sum;
                if (rs_ptr_reg == RSA_W'(MAX_INNER))
                begin
                    a_phase_next = 1'b1;
                    state_next   = S_A_CHK;
                end
                else
                begin
                    rs_ptr_next = rs_ptr_reg + RSA_W'(1);
                    state_next  = S_PFX_RD;
                end
            end
            S_A_CHK:
            begin
                res_next = '{ST_OK, item_reg.row, 6'd0, '0, 1'b1};
                if (17'(item_reg.col) >= inner17)
                begin
                    res_next.status = ST_RANGE;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (row_open_reg && (item_reg.row < cur_row_reg))
                begin
                    res_next.status = ST_ORDER;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    rs_ptr_next = RSA_W'(item_reg.col);
                    if (row_open_reg && (item_reg.row > cur_row_reg))
                    begin
                        fl_j_next     = '0;
                        then_acc_next = 1'b1;
                        state_next    = S_FL_RD;
                    end
                    else
                    begin
                        state_next = S_A_LO;
                    end
                end
            end
            S_A_LO:
            begin
                cur_row_next  = item_reg.row;
                row_open_next = 1'b1;
                rs_ptr_next   = rs_ptr_reg + RSA_W'(1);
                state_next    = S_A_HI;
            end
            S_A_HI:
            begin
                tptr_next  = rs_rd_reg;
                state_next = S_A_HI2;
            end
            S_A_HI2:
            begin
                hi_next = rs_rd_reg;
                if (tptr_reg < rs_rd_reg)
                begin
                    state_next = S_T_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_T_RD:
            begin
                state_next = S_T_MUL;
            end
            S_T_MUL:
            begin
                mac_load     = 1'b1;
                acc_col_next = tcol_rd_reg;
                state_next   = S_T_ACC;
            end
            S_T_ACC:
            begin
                acc_we    = 1'b1;
                acc_waddr = acc_col_reg;
                acc_wdata = mac_out;
                tptr_next = tptr_reg + TT_W'(1);
                if ((tptr_reg + TT_W'(1)) < hi_reg)
                begin
                    state_next = S_T_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FL_RD:
            begin
                state_next = S_FL_CHK;
            end
            S_FL_CHK:
            begin
                acc_we = 1'b1;
                if ((7'(fl_j_reg) < cols7) && (acc_rd_reg != '0))
                begin
                    if (pend_valid_reg)
                    begin
                        res_next = '{ST_OK, cur_row_reg, 6'(pend_col_reg), pend_val_reg, 1'b0};
                        res_valid_next = 1'b1;
                    end
                    pend_col_next   = fl_j_reg;
                    pend_val_next   = sat32(acc_rd_reg);
                    pend_valid_next = 1'b1;
                end
                if (fl_j_reg == AW'(MAX_OUT_COLS - 1))
                begin
                    state_next = S_FL_END;
                end
                else
                begin
                    fl_j_next  = fl_j_reg + AW'(1);
                    state_next = S_FL_RD;
                end
            end
            S_FL_END:
            begin
                if (pend_valid_reg)
                begin
                    res_next = '{ST_OK, cur_row_reg, 6'(pend_col_reg), pend_val_reg, 1'b1};
                    res_valid_next = 1'b1;
                end
                pend_valid_next = 1'b0;
                if (then_acc_reg)
                begin
                    state_next = S_A_LO;
                end
                else
                begin
                    row_open_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            rs_ptr_reg     <= '0;
            term_total_reg <= '0;
            prev_row_reg   <= '0;
            cur_row_reg    <= '0;
            row_open_reg   <= 1'b0;
            a_phase_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            fl_j_reg       <= '0;
            then_acc_reg   <= 1'b0;
            tptr_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            rs_ptr_reg     <= rs_ptr_next;
            term_total_reg <= term_total_next;
            prev_row_reg   <= prev_row_next;
            cur_row_reg    <= cur_row_next;
            row_open_reg   <= row_open_next;
            a_phase_reg    <= a_phase_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            fl_j_reg       <= fl_j_next;
            then_acc_reg   <= then_acc_next;
            tptr_reg       <= tptr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_size_reg <= 9'd256;
            out_cols_reg   <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INNER_SIZE: inner_size_reg <= cfg_data;
                CFG_OUT_COLS:   out_cols_reg   <= cfg_data[6:0];
                default:        inner_size_reg <= inner_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        pend_col_reg <= pend_col_next;
        pend_val_reg <= pend_val_next;
        acc_col_reg  <= acc_col_next;
        hi_reg       <= hi_next;
        run_reg      <= run_next;
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
        begin
            rs_mem[rs_waddr] <= rs_wdata;
        end
        rs_rd_reg <= rs_mem[rs_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rd_reg <= acc_mem[acc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (term_we)
        begin
            tcol_mem[term_total_reg[TA_W-1:0]] <= item_reg.col[AW-1:0];
            tval_mem[term_total_reg[TA_W-1:0]] <= item_reg.value;
        end
        tcol_rd_reg <= tcol_mem[tptr_reg[TA_W-1:0]];
        tval_rd_reg <= tval_mem[tptr_reg[TA_W-1:0]];
    end

    `CHK_ASSERT(a_err_is_last, clk, rst_n, (result_valid && (result.status != ST_OK)) |-> result.last)
    `CHK_ASSERT(a_gap_after_last, clk, rst_n, (result_valid && result.last) |=> !result_valid)
    `CHK_ASSERT(a_store_bound, clk, rst_n, term_total_reg <= TT_W'(MAX_TERMS))

endmodule

/* tb/spmm_checker.sv */
`timescale 1ns / 100ps

module spmm_checker import spmm_pkg::*; #(
    parameter int MAX_TERMS    = 1024,
    parameter int MAX_INNER    = 256,
    parameter int MAX_OUT_COLS = 64,
    parameter int FRAC_BITS    = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  spmm_in_t  item,
    input  logic      result_valid,
    input  spmm_out_t result,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [8:0] cfg_data,
    output int        errors,
    output int        pending
);

    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    logic [8:0]         inner_reg;
    logic [6:0]         cols_reg;
    logic [5:0]         term_col [MAX_TERMS];
    logic signed [31:0] term_val [MAX_TERMS];
    int                 term_total;
    int                 row_start [MAX_INNER + 1];
    longint             acc [MAX_OUT_COLS];
    logic [15:0]        open_row;
    logic               row_open;
    logic               a_phase;
    logic [15:0]        last_b_row;
    spmm_out_t          product_q [$];

    function automatic longint clamp48(input longint v);
        if (v > ACC_HI)
        begin
            return ACC_HI;
        end
        if (v < ACC_LO)
        begin
            return ACC_LO;
        end
        return v;
    endfunction

    function automatic int eff_inner();
        return (inner_reg < MAX_INNER) ? int'(inner_reg) : MAX_INNER;
    endfunction

    function automatic int eff_cols();
        return (cols_reg < MAX_OUT_COLS) ? int'(cols_reg) : MAX_OUT_COLS;
    endfunction

    task automatic clear_all();
        term_total = 0;
        for (int i = 0; i <= MAX_INNER; i++)
        begin
            row_start[i] = 0;
        end
        for (int j = 0; j < MAX_OUT_COLS; j++)
        begin
            acc[j] = 0;
        end
        open_row = '0;
        row_open = 1'b0;
        a_phase = 1'b0;
        last_b_row = '0;
    endtask

    task automatic push_error(input logic [1:0] st, input logic [15:0] r);
        spmm_out_t e;
        e.status = st;
        e.out_row = r;
        e.out_col = '0;
        e.out_value = '0;
        e.last = 1'b1;
        product_q.push_back(e);
    endtask

    task automatic emit_row();
        spmm_out_t row_q [$];
        spmm_out_t e;
        longint v;
        for (int j = 0; j < eff_cols(); j++)
        begin
            v = acc[j];
            if (v != 0)
            begin
                if (v > 64'sd2147483647)
                begin
                    v = 64'sd2147483647;
                end
                if (v < -64'sd2147483648)
                begin
                    v = -64'sd2147483648;
                end
                e.status = ST_OK;
                e.out_row = open_row;
                e.out_col = 6'(j);
                e.out_value = 32'(v);
                e.last = 1'b0;
                row_q.push_back(e);
            end
        end
        if (row_q.size() > 0)
        begin
            row_q[row_q.size() - 1].last = 1'b1;
        end
        foreach (row_q[k])
        begin
            product_q.push_back(row_q[k]);
        end
        for (int j = 0; j < MAX_OUT_COLS; j++)
        begin
            acc[j] = 0;
        end
    endtask

    task automatic model_request(input spmm_in_t it);
        int     r;
        int     c;
        int     lo;
        int     hi;
        longint a;
        longint p;
        r = int'(it.row);
        c = int'(it.col);
        a = longint'($signed(it.value));
        case (it.opcode)
            OP_LOAD:
            begin
                if (r >= eff_inner() || c >= eff_cols())
                begin
                    push_error(ST_RANGE, it.row);
                end
                else if (a_phase || (term_total > 0 && it.row < last_b_row))
                begin
                    push_error(ST_ORDER, it.row);
                end
                else if (term_total >= MAX_TERMS)
                begin
                    push_error(ST_FULL, it.row);
                end
                else
                begin
                    term_col[term_total] = 6'(c);
                    term_val[term_total] = it.value;
                    term_total++;
                    row_start[r + 1]++;
                    last_b_row = it.row;
                end
            end
            OP_A:
            begin
                if (!a_phase)
                begin
                    for (int i = 1; i <= MAX_INNER; i++)
                    begin
                        row_start[i] += row_start[i - 1];
                    end
                    a_phase = 1'b1;
                end
                if (c >= eff_inner())
                begin
                    push_error(ST_RANGE, it.row);
                end
                else if (row_open && it.row < open_row)
                begin
                    push_error(ST_ORDER, it.row);
                end
                else
                begin
                    if (row_open && it.row > open_row)
                    begin
                        emit_row();
                    end
                    open_row = it.row;
                    row_open = 1'b1;
                    lo = row_start[c];
                    hi = (row_start[c + 1] > MAX_TERMS) ? MAX_TERMS : row_start[c + 1];
                    for (int i = lo; i < hi; i++)
                    begin
                        p = clamp48((a * longint'(term_val[i])) >>> FRAC_BITS);
                        acc[term_col[i]] = clamp48(acc[term_col[i]] + p);
                    end
                end
            end
            OP_END:
            begin
                if (row_open)
                begin
                    emit_row();
                    row_open = 1'b0;
                end
            end
            default:
            begin
                clear_all();
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        spmm_out_t e;
        if (!rst_n)
        begin
            inner_reg <= 9'd256;
            cols_reg <= 7'd64;
            clear_all();
            product_q.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (product_q.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("unexpected result: status=%0d row=%0d col=%0d value=%0d last=%0d",
                                 result.status, result.out_row, result.out_col,
                                 result.out_value, result.last);
                    end
                    errors <= errors + 1;
                end
                else
                begin
                    e = product_q.pop_front();
                    if (e.status != result.status || e.out_row != result.out_row ||
                        e.out_col != result.out_col || e.out_value != result.out_value ||
                        e.last != result.last)
                    begin
                        if (errors < 10)
                        begin
                            $display("mismatch: exp status=%0d row=%0d col=%0d value=%0d last=%0d",
                                     e.status, e.out_row, e.out_col, e.out_value, e.last);
                            $display("          got status=%0d row=%0d col=%0d value=%0d last=%0d",
                                     result.status, result.out_row, result.out_col,
                                     result.out_value, result.last);
                        end
                        errors <= errors + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_INNER_SIZE)
                begin
                    inner_reg <= cfg_data;
                end
                else
                begin
                    cols_reg <= cfg_data[6:0];
                end
            end
            if (start && !busy)
            begin
                model_request(item);
            end
            pending <= product_q.size();
        end
    end

endmodule

/* tb/tb_sparse_row_wise_matmul.sv */
`timescale 1ns / 100ps

module tb_sparse_row_wise_matmul;
    import spmm_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    spmm_in_t   item = '0;
    logic       busy;
    logic       result_valid;
    spmm_out_t  result;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_INNER_SIZE;
    logic [8:0] cfg_data = '0;
    int         errors;
    int         pending;
    int         n_requests = 0;
    int         idle_pct = 0;
    int         inner_now = 256;
    int         cols_now = 64;

    always #5 clk = ~clk;

    sparse_row_wise_matmul u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    spmm_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    task automatic send_request(input logic [1:0] op, input logic [15:0] r,
                                input logic [7:0] c, input logic [31:0] v);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        item.opcode = op;
        item.row = r;
        item.col = c;
        item.value = v;
        start = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
        n_requests++;
    endtask

    task automatic drain();
        start = 1'b0;
        wait (pending == 0);
        @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input int data);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = 9'(data);
        if (idx == CFG_INNER_SIZE)
        begin
            inner_now = data;
        end
        else
        begin
            cols_now = data;
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(1 << 18)) - (1 << 17));
        endcase
    endfunction

    task automatic product_run();
        int         nb;
        int         na;
        int         br;
        logic [15:0] ar;
        nb = $urandom_range(1, 12);
        na = $urandom_range(1, 10);
        br = 0;
        for (int k = 0; k < nb; k++)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_request(2'($urandom_range(2)), 16'($urandom), 8'($urandom), $urandom);
            end
            else
            begin
                if ($urandom_range(2) == 0 && br < inner_now - 1)
                begin
                    br = br + 1;
                end
                send_request(OP_LOAD, 16'(br), 8'($urandom_range(cols_now - 1)),
                             rand_value());
            end
        end
        ar = 16'($urandom);
        for (int k = 0; k < na; k++)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_request(2'($urandom_range(2)), 16'($urandom), 8'($urandom), $urandom);
            end
            else
            begin
                if ($urandom_range(2) == 0 && ar != 16'hFFFF)
                begin
                    ar = ar + 16'd1;
                end
                send_request(OP_A, ar, 8'($urandom_range(inner_now - 1)), rand_value());
            end
        end
        send_request(OP_END, 16'($urandom), 8'($urandom), $urandom);
        if ($urandom_range(3) == 0)
        begin
            send_request(OP_A, 16'($urandom), 8'($urandom_range(inner_now - 1)),
                         rand_value());
            send_request(OP_END, 16'($urandom), 8'($urandom), $urandom);
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("** sparse_row_wise_matmul: FAILED **");
        $finish;
    end

    initial
    begin
        int phase;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_INNER_SIZE, 4);
        write_reg(CFG_OUT_COLS, 4);
        send_request(OP_LOAD, 16'd0, 8'd0, 32'h7FFF_FFFF);
        send_request(OP_LOAD, 16'd0, 8'd3, 32'h8000_0000);
        send_request(OP_LOAD, 16'd1, 8'd1, 32'h0001_0000);
        send_request(OP_LOAD, 16'd3, 8'd2, 32'hFFFF_FFFF);
        send_request(OP_LOAD, 16'd4, 8'd0, 32'd1);
        send_request(OP_LOAD, 16'd0, 8'hFF, 32'd1);
        send_request(OP_LOAD, 16'd0, 8'd1, 32'd1);
        send_request(OP_A, 16'd0, 8'd0, 32'h7FFF_FFFF);
        send_request(OP_A, 16'd0, 8'd1, 32'h8000_0000);
        send_request(OP_A, 16'd0, 8'd4, 32'd1);
        send_request(OP_A, 16'd2, 8'd3, 32'h0002_0000);
        send_request(OP_A, 16'd1, 8'd3, 32'd1);
        send_request(OP_LOAD, 16'd3, 8'd3, 32'd1);
        send_request(OP_END, 16'd0, 8'd0, 32'd0);
        send_request(OP_END, 16'd0, 8'd0, 32'd0);
        send_request(OP_A, 16'hFFFF, 8'd0, 32'hFFFF_0000);
        write_reg(CFG_OUT_COLS, 2);
        send_request(OP_END, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_RESTART, 16'd0, 8'd0, 32'd0);

        write_reg(CFG_INNER_SIZE, 1);
        write_reg(CFG_OUT_COLS, 1);
        for (int k = 0; k < 40; k++)
        begin
            send_request(OP_LOAD, 16'd0, 8'd0, 32'($urandom_range(1 << 17)));
        end
        send_request(OP_A, 16'd7, 8'd0, 32'h0001_0000);
        send_request(OP_END, 16'd0, 8'd0, 32'd0);
        send_request(OP_RESTART, 16'd0, 8'd0, 32'd0);

        phase = 0;
        while (n_requests < 300)
        begin
            case (phase % 4)
                0: idle_pct = 0;
                1: idle_pct = 79;
                2: idle_pct = 0;
                default: idle_pct = 26;
            endcase
            case (phase % 5)
                0: write_reg(CFG_INNER_SIZE, 256);
                1: write_reg(CFG_INNER_SIZE, 1);
                default: write_reg(CFG_INNER_SIZE, $urandom_range(2, 16));
            endcase
            case (phase % 6)
                0: write_reg(CFG_OUT_COLS, 64);
                1: write_reg(CFG_OUT_COLS, 1);
                default: write_reg(CFG_OUT_COLS, $urandom_range(2, 16));
            endcase
            product_run();
            send_request(OP_RESTART, 16'($urandom), 8'($urandom), $urandom);
            phase++;
        end

        drain();
        repeat (20) @(negedge clk);
        if (errors == 0)
        begin
            $display("** sparse_row_wise_matmul: PASSED **");
        end
        else
        begin
            $display("** sparse_row_wise_matmul: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/spmm_pkg.sv
hdl/spmm_mac.sv
hdl/sparse_row_wise_matmul.sv
tb/spmm_checker.sv
tb/tb_sparse_row_wise_matmul.sv
